// ===== src/lids_pkg.sv =====
// Shared constants and types of the linear interpolation downsampler.
`timescale 1ns / 1ps
package lids_pkg;

  localparam int unsigned SampleW  = 18;
  localparam int unsigned OutW     = 16;
  localparam int unsigned FracW    = 16;
  localparam int unsigned RatioW   = 20;
  localparam int unsigned Ratio3W  = RatioW + 2;
  localparam int unsigned InDataW  = ((SampleW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8;

  localparam logic [RatioW-1:0]  RatioMin    = 20'd65536;
  localparam logic [RatioW-1:0]  RatioReset  = 20'd196608;
  localparam logic [Ratio3W-1:0] Ratio3Reset = 22'd589824;

  localparam logic signed [OutW-1:0] OutMax = 16'sd32767;
  localparam logic signed [OutW-1:0] OutMin = -16'sd32768;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SampleW:0]   diff_t;
  typedef logic [FracW-1:0]          frac_t;
  typedef logic signed [OutW-1:0]    out_t;

  // Operands of the words that one input sample produces.
  typedef struct packed {
    sample_t a;
    diff_t   d;
    sample_t b;
    frac_t   f;
    logic    last0;
    logic    last1;
  } stage_t;

endpackage

// ===== src/linear_interp_downsampler.sv =====
// Top level of the block-based linear interpolation downsampler.
`timescale 1ns / 1ps
// Usage: input samples (signed Q2.16) arrive on the s_axis channel, one word per sample,
// and form blocks of BLOCK_LEN samples. Output samples (signed 16-bit) leave on m_axis,
// with tlast set on the final output word of a block. The cfg channel writes the
// unsigned Q4.16 ratio step; values below 1.0 act as 1.0. It is always ready and
// should be written only while the block is idle.
// The input word that completes an output word is registered in the operand stage, and
// the result then moves to the output register (one operand stage, one output register).
// Throughput: one input word per cycle unless the receiver stalls. A sample that yields
// two output words holds the stage, as the output register takes one word a cycle.
// When the receiver stalls, the output register holds its word and the operand stage
// fills; s_axis_tready then drops until a word can move on.
// Reset clears the block position, the source phase, the previous sample and all
// valid flags, and sets the ratio step to 3.0.
module linear_interp_downsampler #(
  parameter int unsigned BLOCK_LEN = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lids_pkg::RatioW-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0: in_sample[17:0], then zero padding.
  input  logic [lids_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0: out_sample[15:0].
  output logic [lids_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import lids_pkg::*;

  localparam int unsigned NW  = $clog2(BLOCK_LEN);
  localparam int unsigned PhW = NW + 17;
  localparam int unsigned PW  = NW + 22;
  localparam int unsigned IW  = PhW - 16;
  localparam logic [PW-1:0] End     = PW'(BLOCK_LEN) << 16;
  localparam logic [NW-1:0] LastPos = NW'(BLOCK_LEN - 1);

  logic [RatioW-1:0]  ratio_q, ratio_d;
  logic [Ratio3W-1:0] ratio3_q, ratio3_d;
  sample_t            prev_q;
  logic [NW-1:0]      pos_q, pos_d;
  logic [PhW-1:0]     phase_q, phase_d;
  logic               p0_q, p1_q;
  stage_t             st_q, st_d;
  logic               c0, c1;
  logic               o_valid_q;
  out_t               o_sample_q, o_sample_d;
  logic               o_last_q, o_last_d;

  logic               s_accept, out_free, emit;
  sample_t            cur;
  logic [PW-1:0]      ph0, ph1, ph2, ph3;
  logic [IW-1:0]      int0, int1, pos_ext;

  sample_t                     op_a;
  diff_t                       op_d;
  frac_t                       op_f;
  logic signed [SampleW+FracW:0] prod;
  logic signed [SampleW+FracW+1:0] acc;
  logic signed [SampleW+FracW-16:0] quot;

  // Configuration: clamp once at write time and keep three times the step.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    ratio_d  = (cfg_data_i < RatioMin) ? RatioMin : cfg_data_i;
    ratio3_d = Ratio3W'(ratio_d) + {1'b0, ratio_d, 1'b0};
  end

  // Input side: find the interpolated word and the block end word of this sample.
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign cur      = sample_t'(s_axis_tdata[SampleW-1:0]);
  assign ph0      = PW'(phase_q);
  assign ph1      = ph0 + PW'(ratio_q);
  assign ph2      = ph0 + PW'({ratio_q, 1'b0});
  assign ph3      = ph0 + PW'(ratio3_q);
  assign int0     = phase_q[PhW-1:16];
  assign int1     = ph1[PhW-1:16];
  assign pos_ext  = IW'(pos_q);

  always_comb begin
    c0 = (pos_q != '0) && (ph1 <= End) && (int0 == pos_ext - IW'(1));
    if (c0) begin
      c1       = (pos_q == LastPos) && (ph2 <= End) && (int1 == pos_ext);
      st_d.last0 = ph2 > End;
      st_d.last1 = ph3 > End;
      phase_d  = c1 ? ph2[PhW-1:0] : ph1[PhW-1:0];
    end else begin
      c1       = (pos_q == LastPos) && (ph1 <= End) && (int0 == pos_ext);
      st_d.last0 = 1'b0;
      st_d.last1 = ph2 > End;
      phase_d  = c1 ? ph1[PhW-1:0] : phase_q;
    end
    st_d.a = prev_q;
    st_d.b = cur;
    st_d.d = diff_t'(cur) - diff_t'(prev_q);
    st_d.f = phase_q[FracW-1:0];
    if (pos_q == LastPos) begin
      pos_d   = '0;
      phase_d = '0;
    end else begin
      pos_d = pos_q + NW'(1);
    end
  end

  // Operand stage drains one word per cycle into the output register while it is free.
  assign out_free      = !o_valid_q || m_axis_tready;
  assign emit          = out_free && (p0_q || p1_q);
  assign s_axis_tready = (!p0_q && !p1_q) || (emit && !(p0_q && p1_q));

  // The interpolation a*(1-f)+b*f is formed as a*2^16 + (b-a)*f.
  always_comb begin
    op_a = p0_q ? st_q.a : st_q.b;
    op_d = p0_q ? st_q.d : '0;
    op_f = p0_q ? st_q.f : '0;
    prod = op_d * $signed({1'b0, op_f});
    acc  = $signed({{2{op_a[SampleW-1]}}, op_a, {FracW{1'b0}}}) + (SampleW+FracW+2)'(prod);
    quot = acc[SampleW+FracW+1:17];
    if (acc[SampleW+FracW+1] && (acc[16:0] != '0)) begin
      quot = quot + (SampleW+FracW-15)'(1);
    end
    if (quot > (SampleW+FracW-15)'(OutMax)) begin
      o_sample_d = OutMax;
    end else if (quot < (SampleW+FracW-15)'(OutMin)) begin
      o_sample_d = OutMin;
    end else begin
      o_sample_d = quot[OutW-1:0];
    end
    o_last_d = p0_q ? st_q.last0 : st_q.last1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q   <= RatioReset;
      ratio3_q  <= Ratio3Reset;
      prev_q    <= '0;
      pos_q     <= '0;
      phase_q   <= '0;
      p0_q      <= 1'b0;
      p1_q      <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ratio_q  <= ratio_d;
        ratio3_q <= ratio3_d;
      end
      if (s_accept) begin
        prev_q  <= cur;
        pos_q   <= pos_d;
        phase_q <= phase_d;
        p0_q    <= c0;
        p1_q    <= c1;
      end else if (emit) begin
        if (p0_q) begin
          p0_q <= 1'b0;
        end else begin
          p1_q <= 1'b0;
        end
      end
      if (out_free) begin
        o_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      st_q <= st_d;
    end
    if (emit) begin
      o_sample_q <= o_sample_d;
      o_last_q   <= o_last_d;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = OutDataW'(o_sample_q);
  assign m_axis_tlast  = o_last_q;

  // With both words pending, the stage cannot take a new sample in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p0_q && p1_q) |-> !s_axis_tready)
    else $error("operand stage overrun");

  // A block end word following an interpolated word means the block is not yet over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p0_q && p1_q) |-> !st_q.last0)
    else $error("last flag set on a word that has a successor");

  // The final sample of a block restarts position and phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && (pos_q == LastPos)) |=> ((pos_q == '0) && (phase_q == '0)))
    else $error("block did not restart");

  // The source phase never passes the end of the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(phase_q) <= End)
    else $error("source phase beyond block end");

endmodule
